// ===== hdl/bmc_pkg.sv =====
// Shared types, character codes and sizes for the bracket match checker.
package bmc_pkg;

    // Stack sizing
    localparam int STACK_DEPTH = 1024;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    // Character codes
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_LSQUARE = 8'h5B;
    localparam logic [7:0] CH_LCURLY  = 8'h7B;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_RSQUARE = 8'h5D;
    localparam logic [7:0] CH_RCURLY  = 8'h7D;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_NL      = 8'h0A;

    // Bracket kind as kept on the stack
    localparam logic [1:0] BR_PAREN  = 2'd0;
    localparam logic [1:0] BR_SQUARE = 2'd1;
    localparam logic [1:0] BR_CURLY  = 2'd2;

    // Lexer modes
    typedef enum logic [2:0] {
        LEX_NORMAL     = 3'd0,
        LEX_SLASH      = 3'd1,
        LEX_SQUOTE     = 3'd2,
        LEX_DQUOTE     = 3'd3,
        LEX_LINE       = 3'd4,
        LEX_BLOCK      = 3'd5,
        LEX_BLOCK_STAR = 3'd6
    } t_lex_mode;

    // Result event codes
    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_PUSH = 2'd1,
        EV_POP  = 2'd2,
        EV_DROP = 2'd3
    } t_event;

    // Stack request from the lexer
    typedef struct packed {
        logic       push;
        logic       pop;
        logic [1:0] code;
    } t_lex_op;

    // Stack status seen by the checker
    typedef struct packed {
        logic       empty;
        logic       full;
        logic       one;
        logic [1:0] top;
    } t_stk_stat;

    // Map a stored bracket kind back to its opening character
    function automatic logic [7:0] code_to_char(input logic [1:0] code);
        logic [7:0] c;
        unique case (code)
            BR_SQUARE: c = CH_LSQUARE;
            BR_CURLY:  c = CH_LCURLY;
            default:   c = CH_LPAREN;
        endcase
        return c;
    endfunction

endpackage

// ===== hdl/bmc_lexer.sv =====
// Lexer state machine: tracks quotes and comments and issues stack requests.
module bmc_lexer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_last,
    input  logic [7:0]       i_ch,
    output bmc_pkg::t_lex_op o_op
);

    bmc_pkg::t_lex_mode r_mode;
    bmc_pkg::t_lex_mode n_mode;
    bmc_pkg::t_lex_mode n_norm;
    logic               is_normal;

    // Mode after a byte of plain text
    always_comb begin
        unique case (i_ch)
            bmc_pkg::CH_SQUOTE: n_norm = bmc_pkg::LEX_SQUOTE;
            bmc_pkg::CH_DQUOTE: n_norm = bmc_pkg::LEX_DQUOTE;
            bmc_pkg::CH_SLASH:  n_norm = bmc_pkg::LEX_SLASH;
            default:            n_norm = bmc_pkg::LEX_NORMAL;
        endcase
    end

    // Next state
    always_comb begin
        unique case (r_mode)
            bmc_pkg::LEX_SQUOTE:
                n_mode = (i_ch == bmc_pkg::CH_SQUOTE) ? bmc_pkg::LEX_NORMAL : r_mode;
            bmc_pkg::LEX_DQUOTE:
                n_mode = (i_ch == bmc_pkg::CH_DQUOTE) ? bmc_pkg::LEX_NORMAL : r_mode;
            bmc_pkg::LEX_LINE:
                n_mode = (i_ch == bmc_pkg::CH_NL) ? bmc_pkg::LEX_NORMAL : r_mode;
            bmc_pkg::LEX_BLOCK:
                n_mode = (i_ch == bmc_pkg::CH_STAR) ? bmc_pkg::LEX_BLOCK_STAR : r_mode;
            bmc_pkg::LEX_BLOCK_STAR: begin
                if (i_ch == bmc_pkg::CH_SLASH) begin
                    n_mode = bmc_pkg::LEX_NORMAL;
                end else if (i_ch == bmc_pkg::CH_STAR) begin
                    n_mode = bmc_pkg::LEX_BLOCK_STAR;
                end else begin
                    n_mode = bmc_pkg::LEX_BLOCK;
                end
            end
            bmc_pkg::LEX_SLASH: begin
                if (i_ch == bmc_pkg::CH_SLASH) begin
                    n_mode = bmc_pkg::LEX_LINE;
                end else if (i_ch == bmc_pkg::CH_STAR) begin
                    n_mode = bmc_pkg::LEX_BLOCK;
                end else begin
                    n_mode = n_norm;
                end
            end
            default: n_mode = n_norm;
        endcase
    end

    // Outputs: brackets count only in plain text
    always_comb begin
        is_normal = (r_mode == bmc_pkg::LEX_NORMAL) ||
                    ((r_mode == bmc_pkg::LEX_SLASH) &&
                     (i_ch != bmc_pkg::CH_SLASH) && (i_ch != bmc_pkg::CH_STAR));
        o_op.push = is_normal && ((i_ch == bmc_pkg::CH_LPAREN) ||
                    (i_ch == bmc_pkg::CH_LSQUARE) || (i_ch == bmc_pkg::CH_LCURLY));
        o_op.pop  = is_normal && ((i_ch == bmc_pkg::CH_RPAREN) ||
                    (i_ch == bmc_pkg::CH_RSQUARE) || (i_ch == bmc_pkg::CH_RCURLY));
        if ((i_ch == bmc_pkg::CH_LSQUARE) || (i_ch == bmc_pkg::CH_RSQUARE)) begin
            o_op.code = bmc_pkg::BR_SQUARE;
        end else if ((i_ch == bmc_pkg::CH_LCURLY) || (i_ch == bmc_pkg::CH_RCURLY)) begin
            o_op.code = bmc_pkg::BR_CURLY;
        end else begin
            o_op.code = bmc_pkg::BR_PAREN;
        end
    end

    // Advance mode; return to plain text at end of text
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= bmc_pkg::LEX_NORMAL;
        end else if (i_step) begin
            r_mode <= i_last ? bmc_pkg::LEX_NORMAL : n_mode;
        end
    end

endmodule

// ===== hdl/bmc_stack.sv =====
// Bracket stack: top in a register, lower entries in a RAM with prefetch.
module bmc_stack (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic               i_clear,
    input  bmc_pkg::t_lex_op   i_op,
    output bmc_pkg::t_stk_stat o_stat
);

    logic [1:0]                 r_mem [bmc_pkg::STACK_DEPTH];
    logic [bmc_pkg::CNT_W-1:0]  r_count;
    logic [bmc_pkg::CNT_W-1:0]  n_count;
    logic [1:0]                 r_top;
    logic [1:0]                 r_rd;
    logic [bmc_pkg::CNT_W-1:0]  cnt_m1;
    logic [bmc_pkg::CNT_W-1:0]  nxt_m2;
    logic [bmc_pkg::ADDR_W-1:0] waddr;
    logic [bmc_pkg::ADDR_W-1:0] raddr;
    logic                       full;
    logic                       empty;
    logic                       push_ok;
    logic                       pop_ok;
    logic                       we;

    assign full    = (r_count == bmc_pkg::CNT_W'(bmc_pkg::STACK_DEPTH));
    assign empty   = (r_count == '0);
    assign push_ok = i_step && i_op.push && !full;
    assign pop_ok  = i_step && i_op.pop && !empty;

    // Next fill level
    always_comb begin
        priority if (i_step && i_clear) begin
            n_count = '0;
        end else if (push_ok) begin
            n_count = r_count + bmc_pkg::CNT_W'(1);
        end else if (pop_ok) begin
            n_count = r_count - bmc_pkg::CNT_W'(1);
        end else begin
            n_count = r_count;
        end
    end

    // Spill old top on push; prefetch the entry below the next top
    assign cnt_m1 = r_count - bmc_pkg::CNT_W'(1);
    assign nxt_m2 = n_count - bmc_pkg::CNT_W'(2);
    assign waddr  = cnt_m1[bmc_pkg::ADDR_W-1:0];
    assign raddr  = nxt_m2[bmc_pkg::ADDR_W-1:0];
    assign we     = push_ok && !empty;

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= r_top;
        end
        r_rd <= (we && (waddr == raddr)) ? r_top : r_mem[raddr];
    end

    // Hold the top entry
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_top <= i_op.code;
        end else if (pop_ok) begin
            r_top <= r_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_stat.empty = empty;
    assign o_stat.full  = full;
    assign o_stat.one   = (r_count == bmc_pkg::CNT_W'(1));
    assign o_stat.top   = r_top;

    // Fill level never passes the depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= bmc_pkg::CNT_W'(bmc_pkg::STACK_DEPTH))
        else $error("stack fill level above depth");

    // End of text empties the stack
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_clear |=> r_count == '0)
        else $error("stack not empty after end of text");

    // A taken push puts its kind on top
    a_push_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_ok |=> r_top == $past(i_op.code))
        else $error("pushed bracket not on top");

endmodule

// ===== hdl/bracket_match_checker_core.sv =====
// Top level of the bracket match checker: input register, lexer, stack, result register.
//
// Input channel: i_valid / o_stall with payload i_ch (one text byte) and i_last
// (marks the final byte of a text). A beat is taken when i_valid is high and
// o_stall is low. Output channel: o_valid / i_stall with one result beat per
// input beat: o_event_res, o_bracket, o_failed, o_done_res, o_matched.
//
// Throughput is one byte per cycle while the receiver does not stall: the lexer
// mode, the stack top register and the prefetched entry below it are all updated
// in the same cycle as the byte, so a pop followed by a push or pop in the next
// cycle needs no wait. Each byte passes the input register, then the result
// register, on its way to its result beat.
//
// Reset (synchronous, active low) empties both registers, puts the lexer in
// plain text, empties the stack and clears the failure flag. The stack RAM is
// not cleared; only written entries are read. A beat with i_last set returns
// the block to that same state for the next text.
//
// When the receiver stalls, the result is held and the input register keeps
// one more byte; after that o_stall rises until the result beat is taken.
module bracket_match_checker_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_ch,
    input  logic       i_last,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_event_res,
    output logic [7:0] o_bracket,
    output logic       o_failed,
    output logic       o_done_res,
    output logic       o_matched
);

    logic               r_in_valid;
    logic [7:0]         r_ch;
    logic               r_last;
    logic               r_out_valid;
    logic [1:0]         r_event;
    logic [7:0]         r_bracket;
    logic               r_failed;
    logic               r_done;
    logic               r_matched;
    logic               r_fail;
    logic               adv;
    logic               step;
    logic               n_fail;
    logic               mismatch;
    logic               after_zero;
    bmc_pkg::t_event    n_event;
    logic [7:0]         n_bracket;
    bmc_pkg::t_lex_op   op;
    bmc_pkg::t_stk_stat stat;

    assign adv     = !r_out_valid || !i_stall;
    assign step    = r_in_valid && adv;
    assign o_stall = r_in_valid && !adv;

    // Capture input beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_ch   <= i_ch;
            r_last <= i_last;
        end
    end

    bmc_lexer u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_last  (r_last),
        .i_ch    (r_ch),
        .o_op    (op)
    );

    bmc_stack u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_clear (r_last),
        .i_op    (op),
        .o_stat  (stat)
    );

    // Classify the stack action and update the verdict
    always_comb begin
        mismatch   = op.pop && (stat.empty || (stat.top != op.code));
        n_fail     = r_fail || mismatch;
        after_zero = (stat.empty && !op.push) || (stat.one && op.pop);
        if (op.push) begin
            n_event   = stat.full ? bmc_pkg::EV_DROP : bmc_pkg::EV_PUSH;
            n_bracket = r_ch;
        end else if (op.pop && !stat.empty) begin
            n_event   = bmc_pkg::EV_POP;
            n_bracket = bmc_pkg::code_to_char(stat.top);
        end else begin
            n_event   = bmc_pkg::EV_NONE;
            n_bracket = 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fail <= 1'b0;
        end else if (step) begin
            r_fail <= r_last ? 1'b0 : n_fail;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_event   <= n_event;
            r_bracket <= n_bracket;
            r_failed  <= n_fail;
            r_done    <= r_last;
            r_matched <= r_last && !n_fail && after_zero;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_event_res = r_event;
    assign o_bracket   = r_bracket;
    assign o_failed    = r_failed;
    assign o_done_res  = r_done;
    assign o_matched   = r_matched;

    // A balanced verdict never comes with failure, and only at end of text
    a_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_matched |-> o_done_res && !o_failed)
        else $error("matched verdict with failure or before end of text");

    // No event means no bracket character
    a_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_event_res == bmc_pkg::EV_NONE) |-> o_bracket == 8'h00)
        else $error("bracket character without stack event");

    // Failure stays latched within a text
    a_fail_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && r_fail && !r_last |=> r_fail)
        else $error("failure flag dropped inside a text");

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the bracket match checker: directed script, random texts, scoreboard.
`timescale 1ns / 1ps

module tb;

    // One result beat as the block reports it
    typedef struct packed {
        bmc_pkg::t_event ev;
        logic [7:0]      br;
        logic            failed;
        logic            done;
        logic            matched;
    } t_beat;

    // One scripted input byte; pinned rows carry their result written out by hand
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       pinned;
        t_beat      exp;
    } t_row;

    localparam int N_ROWS    = 28;
    localparam int ITEM_GOAL = 1750;
    localparam int DEEP_OPENS = bmc_pkg::STACK_DEPTH + 2;

    localparam logic [7:0] OPENERS [3] = '{bmc_pkg::CH_LPAREN, bmc_pkg::CH_LSQUARE,
                                           bmc_pkg::CH_LCURLY};
    localparam logic [7:0] CLOSERS [3] = '{bmc_pkg::CH_RPAREN, bmc_pkg::CH_RSQUARE,
                                           bmc_pkg::CH_RCURLY};
    localparam logic [7:0] NOISE   [8] = '{bmc_pkg::CH_STAR, bmc_pkg::CH_SLASH,
                                           bmc_pkg::CH_LPAREN, bmc_pkg::CH_RCURLY,
                                           bmc_pkg::CH_NL, bmc_pkg::CH_SQUOTE,
                                           bmc_pkg::CH_DQUOTE, 8'h61};

    // Directed script: plain nesting, failures, then quotes and comments
    localparam t_row SCRIPT [N_ROWS] = '{
        '{bmc_pkg::CH_LPAREN,  1'b0, 1'b1,
          '{bmc_pkg::EV_PUSH, bmc_pkg::CH_LPAREN,  1'b0, 1'b0, 1'b0}},
        '{bmc_pkg::CH_LSQUARE, 1'b0, 1'b1,
          '{bmc_pkg::EV_PUSH, bmc_pkg::CH_LSQUARE, 1'b0, 1'b0, 1'b0}},
        '{bmc_pkg::CH_RSQUARE, 1'b0, 1'b1,
          '{bmc_pkg::EV_POP,  bmc_pkg::CH_LSQUARE, 1'b0, 1'b0, 1'b0}},
        '{bmc_pkg::CH_RPAREN,  1'b1, 1'b1,
          '{bmc_pkg::EV_POP,  bmc_pkg::CH_LPAREN,  1'b0, 1'b1, 1'b1}},
        '{bmc_pkg::CH_RCURLY,  1'b0, 1'b1,
          '{bmc_pkg::EV_NONE, 8'h00,               1'b1, 1'b0, 1'b0}},
        '{bmc_pkg::CH_LCURLY,  1'b0, 1'b1,
          '{bmc_pkg::EV_PUSH, bmc_pkg::CH_LCURLY,  1'b1, 1'b0, 1'b0}},
        '{bmc_pkg::CH_RSQUARE, 1'b0, 1'b1,
          '{bmc_pkg::EV_POP,  bmc_pkg::CH_LCURLY,  1'b1, 1'b0, 1'b0}},
        '{8'hFF,               1'b1, 1'b1,
          '{bmc_pkg::EV_NONE, 8'h00,               1'b1, 1'b1, 1'b0}},
        '{8'h00,               1'b0, 1'b0, '0},
        '{bmc_pkg::CH_SLASH,   1'b0, 1'b0, '0},
        '{bmc_pkg::CH_SLASH,   1'b0, 1'b0, '0},
        '{bmc_pkg::CH_LPAREN,  1'b0, 1'b0, '0},
        '{bmc_pkg::CH_NL,      1'b0, 1'b0, '0},
        '{bmc_pkg::CH_SQUOTE,  1'b0, 1'b0, '0},
        '{bmc_pkg::CH_LSQUARE, 1'b0, 1'b0, '0},
        '{bmc_pkg::CH_SQUOTE,  1'b0, 1'b0, '0},
        '{bmc_pkg::CH_DQUOTE,  1'b0, 1'b0, '0},
        '{bmc_pkg::CH_LCURLY,  1'b0, 1'b0, '0},
        '{bmc_pkg::CH_DQUOTE,  1'b0, 1'b0, '0},
        '{bmc_pkg::CH_SLASH,   1'b0, 1'b0, '0},
        '{bmc_pkg::CH_STAR,    1'b0, 1'b0, '0},
        '{bmc_pkg::CH_SLASH,   1'b0, 1'b0, '0},
        '{bmc_pkg::CH_STAR,    1'b0, 1'b0, '0},
        '{bmc_pkg::CH_SLASH,   1'b0, 1'b0, '0},
        '{bmc_pkg::CH_SLASH,   1'b0, 1'b0, '0},
        '{bmc_pkg::CH_LPAREN,  1'b0, 1'b0, '0},
        '{bmc_pkg::CH_DQUOTE,  1'b1, 1'b0, '0},
        '{bmc_pkg::CH_SLASH,   1'b1, 1'b1,
          '{bmc_pkg::EV_NONE, 8'h00,               1'b0, 1'b1, 1'b1}}
    };

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_ch;
    logic       i_last;
    logic       o_valid;
    logic       i_stall;
    logic [1:0] o_event_res;
    logic [7:0] o_bracket;
    logic       o_failed;
    logic       o_done_res;
    logic       o_matched;

    // Shadow lexer and bracket stack
    bmc_pkg::t_lex_mode shadow_mode;
    logic [1:0]         shadow_stack [bmc_pkg::STACK_DEPTH];
    int                 shadow_depth;
    logic               shadow_fail;

    t_beat      pending_beats [$];
    logic [7:0] text_q [$];
    logic       calm;
    int         beats_sent;
    int         texts_sent;
    int         errors;
    int         n_push, n_pop, n_drop, n_done, n_match;

    bracket_match_checker_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_ch        (i_ch),
        .i_last      (i_last),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_event_res (o_event_res),
        .o_bracket   (o_bracket),
        .o_failed    (o_failed),
        .o_done_res  (o_done_res),
        .o_matched   (o_matched)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop for a hung handshake
    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Advance the shadow state by one byte and return the beat it should produce
    function automatic t_beat scan_byte(input logic [7:0] ch, input logic last);
        t_beat      r;
        logic       as_text;
        logic [1:0] k;
        logic [1:0] want;
        r       = '0;
        r.ev    = bmc_pkg::EV_NONE;
        as_text = 1'b0;
        case (shadow_mode)
            bmc_pkg::LEX_SQUOTE:
                if (ch == bmc_pkg::CH_SQUOTE) shadow_mode = bmc_pkg::LEX_NORMAL;
            bmc_pkg::LEX_DQUOTE:
                if (ch == bmc_pkg::CH_DQUOTE) shadow_mode = bmc_pkg::LEX_NORMAL;
            bmc_pkg::LEX_LINE:
                if (ch == bmc_pkg::CH_NL) shadow_mode = bmc_pkg::LEX_NORMAL;
            bmc_pkg::LEX_BLOCK:
                if (ch == bmc_pkg::CH_STAR) shadow_mode = bmc_pkg::LEX_BLOCK_STAR;
            bmc_pkg::LEX_BLOCK_STAR: begin
                if (ch == bmc_pkg::CH_SLASH) shadow_mode = bmc_pkg::LEX_NORMAL;
                else if (ch != bmc_pkg::CH_STAR) shadow_mode = bmc_pkg::LEX_BLOCK;
            end
            bmc_pkg::LEX_SLASH: begin
                if (ch == bmc_pkg::CH_SLASH) shadow_mode = bmc_pkg::LEX_LINE;
                else if (ch == bmc_pkg::CH_STAR) shadow_mode = bmc_pkg::LEX_BLOCK;
                else as_text = 1'b1;
            end
            default: as_text = 1'b1;
        endcase

        // Plain text: quotes and slash change mode, brackets work the stack
        if (as_text) begin
            shadow_mode = bmc_pkg::LEX_NORMAL;
            case (ch)
                bmc_pkg::CH_SQUOTE: shadow_mode = bmc_pkg::LEX_SQUOTE;
                bmc_pkg::CH_DQUOTE: shadow_mode = bmc_pkg::LEX_DQUOTE;
                bmc_pkg::CH_SLASH:  shadow_mode = bmc_pkg::LEX_SLASH;
                bmc_pkg::CH_LPAREN, bmc_pkg::CH_LSQUARE, bmc_pkg::CH_LCURLY: begin
                    k    = (ch == bmc_pkg::CH_LPAREN) ? bmc_pkg::BR_PAREN :
                           (ch == bmc_pkg::CH_LSQUARE) ? bmc_pkg::BR_SQUARE :
                           bmc_pkg::BR_CURLY;
                    r.br = ch;
                    if (shadow_depth >= bmc_pkg::STACK_DEPTH) begin
                        r.ev = bmc_pkg::EV_DROP;
                    end else begin
                        shadow_stack[shadow_depth] = k;
                        shadow_depth++;
                        r.ev = bmc_pkg::EV_PUSH;
                    end
                end
                bmc_pkg::CH_RPAREN, bmc_pkg::CH_RSQUARE, bmc_pkg::CH_RCURLY: begin
                    want = (ch == bmc_pkg::CH_RPAREN) ? bmc_pkg::BR_PAREN :
                           (ch == bmc_pkg::CH_RSQUARE) ? bmc_pkg::BR_SQUARE :
                           bmc_pkg::BR_CURLY;
                    if (shadow_depth == 0) begin
                        shadow_fail = 1'b1;
                    end else begin
                        shadow_depth--;
                        k    = shadow_stack[shadow_depth];
                        r.ev = bmc_pkg::EV_POP;
                        r.br = (k == bmc_pkg::BR_SQUARE) ? bmc_pkg::CH_LSQUARE :
                               (k == bmc_pkg::BR_CURLY) ? bmc_pkg::CH_LCURLY :
                               bmc_pkg::CH_LPAREN;
                        if (k != want) shadow_fail = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        r.failed = shadow_fail;
        r.done   = last;
        // Give the verdict and start over for the next text
        if (last) begin
            r.matched    = !shadow_fail && (shadow_depth == 0);
            shadow_mode  = bmc_pkg::LEX_NORMAL;
            shadow_depth = 0;
            shadow_fail  = 1'b0;
        end
        return r;
    endfunction

    // Offer one beat, hold it through stalls, then record what it should produce
    task automatic send_beat(input logic [7:0] ch, input logic last,
                             input logic pinned, input t_beat pinned_exp);
        t_beat predicted;
        calm = (beats_sent >= 400) && (beats_sent < 700);
        while (!calm && $urandom_range(0, 99) < 21) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_ch    <= ch;
        i_last  <= last;
        do @(posedge i_clk); while (o_stall);
        predicted = scan_byte(ch, last);
        pending_beats.push_back(pinned ? pinned_exp : predicted);
        beats_sent++;
    endtask

    // Hold off the sender until every pending result is back
    task automatic drain_wait();
        i_valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Build a random text: mostly nested brackets, strings and comments, some noise
    task automatic build_text(input int n);
        int         open_k [$];
        int         roll;
        int         k;
        logic [7:0] q;
        text_q.delete();
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 25) begin
                k = $urandom_range(0, 2);
                open_k.push_back(k);
                text_q.push_back(OPENERS[k]);
            end else if (roll < 45) begin
                if (open_k.size() != 0) text_q.push_back(CLOSERS[open_k.pop_back()]);
                else text_q.push_back(CLOSERS[$urandom_range(0, 2)]);
            end else if (roll < 50) begin
                text_q.push_back(CLOSERS[$urandom_range(0, 2)]);
            end else if (roll < 60) begin
                q = $urandom_range(0, 1) ? bmc_pkg::CH_SQUOTE : bmc_pkg::CH_DQUOTE;
                text_q.push_back(q);
                repeat ($urandom_range(0, 4)) text_q.push_back(NOISE[$urandom_range(0, 7)]);
                text_q.push_back(q);
            end else if (roll < 65) begin
                text_q.push_back(bmc_pkg::CH_SLASH);
                text_q.push_back(bmc_pkg::CH_SLASH);
                repeat ($urandom_range(0, 4)) text_q.push_back(NOISE[$urandom_range(0, 7)]);
                text_q.push_back(bmc_pkg::CH_NL);
            end else if (roll < 70) begin
                text_q.push_back(bmc_pkg::CH_SLASH);
                text_q.push_back(bmc_pkg::CH_STAR);
                repeat ($urandom_range(0, 5)) text_q.push_back(NOISE[$urandom_range(0, 7)]);
                text_q.push_back(bmc_pkg::CH_STAR);
                text_q.push_back(bmc_pkg::CH_SLASH);
            end else if (roll < 78) begin
                text_q.push_back(bmc_pkg::CH_SLASH);
                text_q.push_back(8'($urandom_range(0, 255)));
            end else begin
                text_q.push_back(8'($urandom_range(0, 255)));
            end
        end
        // Close what is still open in most texts
        if ($urandom_range(0, 99) < 80) begin
            while (open_k.size() != 0) text_q.push_back(CLOSERS[open_k.pop_back()]);
        end
    endtask

    // Result receiver: random stalls, calm during the quiet stretch
    always @(posedge i_clk) begin
        i_stall <= !calm && ($urandom_range(0, 99) < 21);
    end

    task automatic check_field(input string name, input int exp_v, input int got_v);
        if (exp_v != got_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, got_v);
            errors++;
        end
    endtask

    // Scoreboard: compare each taken result beat with the oldest pending one
    always @(posedge i_clk) begin
        t_beat w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_beats.size() == 0) begin
                $error("result beat with nothing pending");
                errors++;
            end else begin
                w = pending_beats.pop_front();
                check_field("event_res", int'(w.ev), int'(o_event_res));
                check_field("bracket", int'(w.br), int'(o_bracket));
                check_field("failed", int'(w.failed), int'(o_failed));
                check_field("done_res", int'(w.done), int'(o_done_res));
                check_field("matched", int'(w.matched), int'(o_matched));
                if (o_event_res == bmc_pkg::EV_PUSH) n_push++;
                if (o_event_res == bmc_pkg::EV_POP) n_pop++;
                if (o_event_res == bmc_pkg::EV_DROP) n_drop++;
                if (o_done_res) n_done++;
                if (o_done_res && o_matched) n_match++;
            end
        end
    end

    // Main sequence
    initial begin
        logic deep_done;
        logic deep_now;
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_ch       <= 8'h00;
        i_last     <= 1'b0;
        calm        = 1'b0;
        beats_sent  = 0;
        texts_sent  = 0;
        errors      = 0;
        n_push = 0; n_pop = 0; n_drop = 0; n_done = 0; n_match = 0;
        shadow_mode  = bmc_pkg::LEX_NORMAL;
        shadow_depth = 0;
        shadow_fail  = 1'b0;
        deep_done    = 1'b0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed script
        foreach (SCRIPT[i]) begin
            send_beat(SCRIPT[i].ch, SCRIPT[i].last, SCRIPT[i].pinned, SCRIPT[i].exp);
        end
        drain_wait();

        // Random texts, with one text deep enough to overflow the stack
        while (beats_sent < ITEM_GOAL) begin
            deep_now = !deep_done && (beats_sent > 300);
            if (deep_now) begin
                text_q.delete();
                repeat (DEEP_OPENS) text_q.push_back(OPENERS[$urandom_range(0, 2)]);
                repeat (3) text_q.push_back(CLOSERS[$urandom_range(0, 2)]);
                deep_done = 1'b1;
            end else if ($urandom_range(0, 9) == 0) begin
                build_text($urandom_range(40, 120));
            end else begin
                build_text($urandom_range(1, 30));
            end
            foreach (text_q[i]) send_beat(text_q[i], i == text_q.size() - 1, 1'b0, '0);
            texts_sent++;
            if (deep_now) drain_wait();
        end

        // Let the last results come back
        i_valid <= 1'b0;
        for (int w = 0; w < 20000 && pending_beats.size() != 0; w++) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (pending_beats.size() != 0) begin
            $error("%0d result beats never arrived", pending_beats.size());
            errors++;
        end

        $display("Sent %0d bytes in %0d random texts plus the script; %0d verdicts, %0d %s",
                 beats_sent, texts_sent, n_done, n_match, "balanced.");
        $display("Stack traffic: %0d pushes, %0d pops, %0d dropped on a full stack; %0d errors.",
                 n_push, n_pop, n_drop, errors);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
